// File: hdl/symmetric_3x3_inverse_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric 3x3 inverse core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_3X3_INVERSE_CORE_DEFINES_SVH
`define SYMMETRIC_3X3_INVERSE_CORE_DEFINES_SVH

// implication checked on the same edge
`define SYM3_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// implication checked on the next edge
`define SYM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

// File: hdl/sym3_pkg.sv
// ----------------------------------------------------------------------------
// Symmetric 3x3 inverse package
// Widths, lane counts and pipeline depth shared by the core and its checker.
// ----------------------------------------------------------------------------
package sym3_pkg;
   localparam int LANES        = 6;
   localparam int QUO_BITS     = 32;
   localparam int ENT_W        = 24;
   localparam int PROD_W       = 48;
   localparam int COF_W        = 49;
   localparam int CMAG_W       = 48;
   localparam int PP_W         = 49;
   localparam int DET_W        = 74;
   localparam int DMAG_W       = 72;
   localparam int REM_W        = CMAG_W + QUO_BITS;
   localparam int CMP_W        = DMAG_W + QUO_BITS + 1;
   localparam int DV_W         = 41;
   localparam int OUT_W        = 32;
   localparam int NUM_PROD     = 12;
   localparam int PIPE_LATENCY = 6 + QUO_BITS;

   localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef logic signed [ENT_W-1:0] entry_type;
   typedef logic signed [COF_W-1:0] cof_type;
endpackage

// File: hdl/symmetric_3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// Symmetric 3x3 inverse core
// Adjugate-based inverse of one symmetric Q8.16 matrix per transfer.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns its result on a one-cycle
// rsp_valid strobe; results cannot be held off. Five stages form
// products, cofactors, split 49x24 partial products, the determinant
// and magnitudes; 32 stages run a restoring divide, one quotient bit per
// stage for all six lanes; a last stage applies sign, saturation and the
// singular case. busy is high only during reset.
module symmetric_3x3_inverse_core
   import sym3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [ENT_W-1:0] req_a00,
   input  logic signed [ENT_W-1:0] req_a11,
   input  logic signed [ENT_W-1:0] req_a22,
   input  logic signed [ENT_W-1:0] req_a01,
   input  logic signed [ENT_W-1:0] req_a02,
   input  logic signed [ENT_W-1:0] req_a12,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_inv00,
   output logic signed [OUT_W-1:0] rsp_inv11,
   output logic signed [OUT_W-1:0] rsp_inv22,
   output logic signed [OUT_W-1:0] rsp_inv01,
   output logic signed [OUT_W-1:0] rsp_inv02,
   output logic signed [OUT_W-1:0] rsp_inv12,
   output logic signed [DV_W-1:0]  rsp_det_value,
   output logic                    rsp_singular
);

   logic                     accept;
   logic [3:0]               vld_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_PROD];
   entry_type                e1_ff [3];
   entry_type                e2_ff [3];
   cof_type                  cof2_ff [LANES];
   cof_type                  cof3_ff [LANES];
   cof_type                  cof4_ff [LANES];
   logic signed [PP_W-1:0]   pphi_ff [3];
   logic signed [PP_W-1:0]   pplo_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  det_sum;

   logic                     dvld_in  [QUO_BITS+1];
   logic                     dvld_ff  [QUO_BITS+1];
   logic [DMAG_W-1:0]        dmag_in  [QUO_BITS+1];
   logic [DMAG_W-1:0]        dmag_ff  [QUO_BITS+1];
   logic                     sing_in  [QUO_BITS+1];
   logic                     sing_ff  [QUO_BITS+1];
   logic [DV_W-1:0]          dv_in    [QUO_BITS+1];
   logic [DV_W-1:0]          dv_ff    [QUO_BITS+1];
   logic [REM_W-1:0]         rem_in   [QUO_BITS+1][LANES];
   logic [REM_W-1:0]         rem_ff   [QUO_BITS+1][LANES];
   logic [QUO_BITS-1:0]      quo_in   [QUO_BITS+1][LANES];
   logic [QUO_BITS-1:0]      quo_ff   [QUO_BITS+1][LANES];
   logic                     ovf_in   [QUO_BITS+1][LANES];
   logic                     ovf_ff   [QUO_BITS+1][LANES];
   logic                     qneg_in  [QUO_BITS+1][LANES];
   logic                     qneg_ff  [QUO_BITS+1][LANES];

   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         inv_in [LANES];
   logic [OUT_W-1:0]         inv_ff [LANES];
   logic [DV_W-1:0]          det_out_ff;
   logic                     sing_out_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // stages 1 to 4: products, cofactors, partial products, determinant
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], accept};
      end
      prod_ff[0]  <= req_a11 * req_a22;
      prod_ff[1]  <= req_a12 * req_a12;
      prod_ff[2]  <= req_a00 * req_a22;
      prod_ff[3]  <= req_a02 * req_a02;
      prod_ff[4]  <= req_a00 * req_a11;
      prod_ff[5]  <= req_a01 * req_a01;
      prod_ff[6]  <= req_a02 * req_a12;
      prod_ff[7]  <= req_a22 * req_a01;
      prod_ff[8]  <= req_a01 * req_a12;
      prod_ff[9]  <= req_a11 * req_a02;
      prod_ff[10] <= req_a01 * req_a02;
      prod_ff[11] <= req_a00 * req_a12;
      e1_ff[0] <= req_a00;
      e1_ff[1] <= req_a01;
      e1_ff[2] <= req_a02;
      e2_ff    <= e1_ff;
      for (int l = 0; l < LANES; l++) begin
         cof2_ff[l] <= COF_W'(prod_ff[2*l]) - COF_W'(prod_ff[2*l+1]);
      end
      cof3_ff <= cof2_ff;
      cof4_ff <= cof3_ff;
      det_ff  <= det_sum;
   end

   // cofactor lanes: c00 c11 c22 c01 c02 c12; row 0 uses lanes 0, 3, 4
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         pphi_ff[j] <= $signed(cof2_ff[(j == 0) ? 0 : j + 2][COF_W-1:ENT_W]) * e2_ff[j];
         pplo_ff[j] <= $signed({1'b0, cof2_ff[(j == 0) ? 0 : j + 2][ENT_W-1:0]})
                       * e2_ff[j];
      end
   end

   always_comb begin
      det_sum = '0;
      for (int j = 0; j < 3; j++) begin
         det_sum = det_sum + (DET_W'(pphi_ff[j]) <<< ENT_W) + DET_W'(pplo_ff[j]);
      end
   end

   // stage 5 setup and divide stages
   always_comb begin
      logic [DMAG_W-1:0]  dmag;
      logic               dneg;
      logic [CMAG_W-1:0]  cmag;
      logic [CMP_W-1:0]   trial;
      logic [CMP_W-1:0]   cur;
      dneg       = det_ff[DET_W-1];
      dmag       = DMAG_W'(dneg ? -det_ff : det_ff);
      dvld_in[0] = vld_ff[3];
      dmag_in[0] = dmag;
      sing_in[0] = (det_ff == '0);
      dv_in[0]   = dneg ? -DV_W'(dmag >> QUO_BITS) : DV_W'(dmag >> QUO_BITS);
      for (int l = 0; l < LANES; l++) begin
         cmag             = CMAG_W'(cof4_ff[l][COF_W-1] ? -cof4_ff[l] : cof4_ff[l]);
         qneg_in[0][l]    = cof4_ff[l][COF_W-1] ^ dneg;
         ovf_in[0][l]     = {{(DMAG_W-CMAG_W){1'b0}}, cmag} >= dmag;
         rem_in[0][l]     = {cmag, {QUO_BITS{1'b0}}};
         quo_in[0][l]     = '0;
      end
      for (int s = 0; s < QUO_BITS; s++) begin
         dvld_in[s+1] = dvld_ff[s];
         dmag_in[s+1] = dmag_ff[s];
         sing_in[s+1] = sing_ff[s];
         dv_in[s+1]   = dv_ff[s];
         trial        = CMP_W'(dmag_ff[s]) << (QUO_BITS - 1 - s);
         for (int l = 0; l < LANES; l++) begin
            cur              = CMP_W'(rem_ff[s][l]);
            ovf_in[s+1][l]   = ovf_ff[s][l];
            qneg_in[s+1][l]  = qneg_ff[s][l];
            rem_in[s+1][l]   = rem_ff[s][l];
            quo_in[s+1][l]   = quo_ff[s][l];
            if (cur >= trial) begin
               rem_in[s+1][l] = REM_W'(cur - trial);
               quo_in[s+1][l][QUO_BITS-1-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= QUO_BITS; s++) begin
         if (reset) begin
            dvld_ff[s] <= 1'b0;
         end else begin
            dvld_ff[s] <= dvld_in[s];
         end
         dmag_ff[s] <= dmag_in[s];
         sing_ff[s] <= sing_in[s];
         dv_ff[s]   <= dv_in[s];
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
         ovf_ff[s]  <= ovf_in[s];
         qneg_ff[s] <= qneg_in[s];
      end
   end

   // output stage: sign, saturation, singular
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (sing_ff[QUO_BITS]) begin
            inv_in[l] = '0;
         end else if (ovf_ff[QUO_BITS][l]) begin
            inv_in[l] = qneg_ff[QUO_BITS][l] ? SAT_MIN : SAT_MAX;
         end else if (qneg_ff[QUO_BITS][l]) begin
            inv_in[l] = (quo_ff[QUO_BITS][l] > SAT_MIN) ? SAT_MIN : -quo_ff[QUO_BITS][l];
         end else begin
            inv_in[l] = (quo_ff[QUO_BITS][l] > SAT_MAX) ? SAT_MAX : quo_ff[QUO_BITS][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvld_ff[QUO_BITS];
      end
      inv_ff      <= inv_in;
      det_out_ff  <= dv_ff[QUO_BITS];
      sing_out_ff <= sing_ff[QUO_BITS];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inv00     = $signed(inv_ff[0]);
   assign rsp_inv11     = $signed(inv_ff[1]);
   assign rsp_inv22     = $signed(inv_ff[2]);
   assign rsp_inv01     = $signed(inv_ff[3]);
   assign rsp_inv02     = $signed(inv_ff[4]);
   assign rsp_inv12     = $signed(inv_ff[5]);
   assign rsp_det_value = $signed(det_out_ff);
   assign rsp_singular  = sing_out_ff;

endmodule

// File: hdl/sym3_checker.sv
// ----------------------------------------------------------------------------
// Symmetric 3x3 inverse port checker
// Port-level assertions on latency, busy and the singular result.
// ----------------------------------------------------------------------------
`include "symmetric_3x3_inverse_core_defines.svh"

module sym3_checker
   import sym3_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_inv00,
   input logic signed [OUT_W-1:0] rsp_inv11,
   input logic signed [OUT_W-1:0] rsp_inv22,
   input logic signed [OUT_W-1:0] rsp_inv01,
   input logic signed [OUT_W-1:0] rsp_inv02,
   input logic signed [OUT_W-1:0] rsp_inv12,
   input logic signed [DV_W-1:0]  rsp_det_value,
   input logic                    rsp_singular
);

   logic in_transfer;
   logic inv_zero;
   logic det_zero;

   assign in_transfer = start && !busy;
   assign inv_zero    = (rsp_inv00 == '0) && (rsp_inv11 == '0) && (rsp_inv22 == '0)
                     && (rsp_inv01 == '0) && (rsp_inv02 == '0) && (rsp_inv12 == '0);
   assign det_zero    = (rsp_det_value == '0);

   `SYM3_ASSERT_SAME(a_rsp_latency, clock, reset, rsp_valid, $past(in_transfer, PIPE_LATENCY))
   `SYM3_ASSERT_SAME(a_singular_zero, clock, reset, rsp_valid && rsp_singular, inv_zero && det_zero)
   `SYM3_ASSERT_NEXT(a_busy_reset, clock, reset, !reset, !busy)

endmodule

bind symmetric_3x3_inverse_core sym3_checker u_sym3_checker (.*);

// File: tb/tb_symmetric_3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// Symmetric 3x3 inverse core testbench
// Drives matrices with random start gaps, predicts the determinant and the
// truncated, saturated adjugate quotients exactly, checks every rsp transfer.
// ----------------------------------------------------------------------------
module tb_symmetric_3x3_inverse_core
   import sym3_pkg::*;
();

   typedef struct {
      entry_type a00, a11, a22, a01, a02, a12;
   } matrix_type;

   typedef struct {
      logic signed [OUT_W-1:0] inv00, inv11, inv22, inv01, inv02, inv12;
      logic signed [DV_W-1:0]  det_value;
      logic                    singular;
   } inverse_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   entry_type               req_a00, req_a11, req_a22, req_a01, req_a02, req_a12;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_inv00, rsp_inv11, rsp_inv22;
   logic signed [OUT_W-1:0] rsp_inv01, rsp_inv02, rsp_inv12;
   logic signed [DV_W-1:0]  rsp_det_value;
   logic                    rsp_singular;

   matrix_type  pending_matrices[$];
   inverse_type expected_inverses[$];
   int          gap_left;
   int          errors = 0;

   symmetric_3x3_inverse_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [OUT_W-1:0] quotient_q16(longint adj, logic [127:0] dmag,
                                                     bit dneg);
      logic [127:0] num;
      logic [127:0] q;
      bit           neg;
      neg = (adj < 0) != dneg;
      num = 128'(adj < 0 ? -adj : adj) << 32;
      q   = num / dmag;
      if (q >= 128'h8000_0000) return neg ? SAT_MIN : SAT_MAX;
      return neg ? OUT_W'(-q) : OUT_W'(q);
   endfunction

   function automatic inverse_type invert_symmetric(matrix_type m);
      longint              a00, a11, a22, a01, a02, a12;
      longint              c00, c11, c22, c01, c02, c12;
      logic signed [127:0] det;
      logic [127:0]        dmag;
      logic [127:0]        dv;
      bit                  dneg;
      inverse_type         r;
      a00 = m.a00; a11 = m.a11; a22 = m.a22;
      a01 = m.a01; a02 = m.a02; a12 = m.a12;
      c00 = a11 * a22 - a12 * a12;
      c11 = a00 * a22 - a02 * a02;
      c22 = a00 * a11 - a01 * a01;
      c01 = a02 * a12 - a22 * a01;
      c02 = a01 * a12 - a11 * a02;
      c12 = a01 * a02 - a00 * a12;
      det = 128'(c00) * 128'(a00) + 128'(c01) * 128'(a01) + 128'(c02) * 128'(a02);
      dneg = det < 0;
      dmag = dneg ? -det : det;
      dv = dmag >> 32;
      if (dneg) dv = -dv;
      r.det_value = dv[DV_W-1:0];
      if (det == 0) begin
         r.singular = 1'b1;
         r.inv00 = '0; r.inv11 = '0; r.inv22 = '0;
         r.inv01 = '0; r.inv02 = '0; r.inv12 = '0;
      end else begin
         r.singular = 1'b0;
         r.inv00 = quotient_q16(c00, dmag, dneg);
         r.inv11 = quotient_q16(c11, dmag, dneg);
         r.inv22 = quotient_q16(c22, dmag, dneg);
         r.inv01 = quotient_q16(c01, dmag, dneg);
         r.inv02 = quotient_q16(c02, dmag, dneg);
         r.inv12 = quotient_q16(c12, dmag, dneg);
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
         req_a00  <= '0; req_a11 <= '0; req_a22 <= '0;
         req_a01  <= '0; req_a02 <= '0; req_a12 <= '0;
      end else begin
         if (start && !busy) begin
            expected_inverses.insert(expected_inverses.size(), invert_symmetric(
               '{req_a00, req_a11, req_a22, req_a01, req_a02, req_a12}));
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_matrices.size() > 0) begin
            matrix_type m;
            m = pending_matrices.pop_front();
            req_a00 <= m.a00; req_a11 <= m.a11; req_a22 <= m.a22;
            req_a01 <= m.a01; req_a02 <= m.a02; req_a12 <= m.a12;
            start    <= 1'b1;
            gap_left <= ($urandom_range(0, 7) == 0) ? 0 : pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [DV_W-1:0] exp_v, logic [DV_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            $error("rsp transfer with no matrix outstanding");
            errors++;
         end else begin
            inverse_type e;
            e = expected_inverses.pop_front();
            check_field("inv00", DV_W'(e.inv00), DV_W'(rsp_inv00));
            check_field("inv11", DV_W'(e.inv11), DV_W'(rsp_inv11));
            check_field("inv22", DV_W'(e.inv22), DV_W'(rsp_inv22));
            check_field("inv01", DV_W'(e.inv01), DV_W'(rsp_inv01));
            check_field("inv02", DV_W'(e.inv02), DV_W'(rsp_inv02));
            check_field("inv12", DV_W'(e.inv12), DV_W'(rsp_inv12));
            check_field("det_value", e.det_value, rsp_det_value);
            check_field("singular", DV_W'(e.singular), DV_W'(rsp_singular));
         end
      end
   end

   function automatic entry_type rand_entry();
      return entry_type'($urandom);
   endfunction

   task automatic add_matrix(int d0, int d1, int d2, int o01, int o02, int o12);
      pending_matrices.insert(pending_matrices.size(),
                              '{entry_type'(d0), entry_type'(d1), entry_type'(d2),
                                entry_type'(o01), entry_type'(o02), entry_type'(o12)});
   endtask

   initial begin
      localparam int ONE  = 65536;
      localparam int EMAX = 8388607;
      localparam int EMIN = -8388608;
      int         kind;
      int         v0, v1, v2, s;
      matrix_type m;
      reset   = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_matrix(0, 0, 0, 0, 0, 0);
      add_matrix(ONE, ONE, ONE, 0, 0, 0);
      add_matrix(-ONE, -ONE, -ONE, 0, 0, 0);
      add_matrix(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX);
      add_matrix(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN);
      add_matrix(EMAX, EMAX, EMAX, 0, 0, 0);
      add_matrix(EMIN, EMIN, EMIN, 0, 0, 0);
      add_matrix(EMIN, EMAX, EMIN, EMAX, EMIN, EMAX);
      add_matrix(EMAX, EMIN, EMAX, EMIN, EMAX, EMIN);
      add_matrix(1, 1, 1, 0, 0, 0);
      add_matrix(-1, 1, 1, 0, 0, 0);
      add_matrix(1, 1, 1, 1, 1, 1);
      add_matrix(ONE, ONE, ONE, ONE, ONE, ONE);
      add_matrix(2, 3, 5, 1, 1, 1);
      add_matrix(ONE, 2 * ONE, 4 * ONE, ONE / 2, -ONE / 4, ONE / 8);
      add_matrix(EMAX, 1, EMAX, 0, 0, 0);
      add_matrix(0, ONE, ONE, ONE, 0, 0);
      add_matrix(0, 0, 0, ONE, ONE, ONE);
      add_matrix(0, 0, 0, EMIN, EMIN, EMIN);
      add_matrix(0, 0, 0, EMAX, EMAX, EMAX);
      add_matrix(ONE, ONE, 0, ONE, 0, 0);
      add_matrix(-1, -1, -1, -1, -1, -1);
      add_matrix(-ONE, 0, 0, 0, -ONE, -ONE);

      // random
      for (int n = 0; n < 1830; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            m = '{rand_entry(), rand_entry(), rand_entry(),
                  rand_entry(), rand_entry(), rand_entry()};
         end else if (kind < 6) begin
            // well conditioned: dominant diagonal, small off-diagonal
            s = $urandom_range(4, 23);
            m.a00 = entry_type'(($urandom_range(0, 1) ? -1 : 1) * (1 << s)
                                + $signed($urandom_range(0, 1 << (s - 2))));
            m.a11 = entry_type'(($urandom_range(0, 1) ? -1 : 1) * (1 << (s - 1))
                                + $signed($urandom_range(0, 1 << (s - 2))));
            m.a22 = entry_type'(($urandom_range(0, 1) ? -1 : 1) * (1 << (s - 1))
                                + $signed($urandom_range(0, 1 << (s - 2))));
            m.a01 = entry_type'($signed($urandom_range(0, 1 << (s - 3))) - (1 << (s - 4)));
            m.a02 = entry_type'($signed($urandom_range(0, 1 << (s - 3))) - (1 << (s - 4)));
            m.a12 = entry_type'($signed($urandom_range(0, 1 << (s - 3))) - (1 << (s - 4)));
         end else if (kind < 8) begin
            // rank one: v * v^T, singular
            v0 = $signed($urandom_range(0, 4094)) - 2047;
            v1 = $signed($urandom_range(0, 4094)) - 2047;
            v2 = $signed($urandom_range(0, 4094)) - 2047;
            m = '{entry_type'(v0 * v0), entry_type'(v1 * v1), entry_type'(v2 * v2),
                  entry_type'(v0 * v1), entry_type'(v0 * v2), entry_type'(v1 * v2)};
         end else begin
            // small entries: tiny determinants
            s = $urandom_range(1, 12);
            m = '{entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s)),
                  entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s)),
                  entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s)),
                  entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s)),
                  entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s)),
                  entry_type'($signed($urandom_range(0, 2 << s)) - (1 << s))};
         end
         pending_matrices.insert(pending_matrices.size(), m);
      end

      wait (pending_matrices.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (expected_inverses.size() > 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
